// File: design/byte_range_header_parser_top_macros.svh
// Assertion macros for the byte range header parser.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef BYTE_RANGE_HEADER_PARSER_TOP_MACROS_SVH
`define BYTE_RANGE_HEADER_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BRHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRHP_ASSERT_NOW(label, ante, cons, msg)
`define BRHP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: design/brhp_pkg.sv
// Shared types and constants for the byte range header parser.
// No dependencies.
package brhp_pkg;

    localparam int OFFSET_BITS_DEFAULT = 48;
    localparam int FIELD_BITS          = 48;
    localparam int PREFIX_LEN          = 6;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]            header_char;
        logic                  char_present;
        logic                  is_final;
        logic [FIELD_BITS-1:0] object_size;
    } in_item_t;

    typedef struct packed {
        logic                  satisfiable;
        logic [FIELD_BITS-1:0] range_first;
        logic [FIELD_BITS-1:0] range_last;
        logic [FIELD_BITS-1:0] range_length;
    } out_item_t;

    // expected character of "bytes=" at each prefix position
    function automatic logic [7:0] lead_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3D;
            default: c = CH_COMMA; // never matches in a valid header
        endcase
        return c;
    endfunction

endpackage

// File: design/byte_range_header_parser_top.sv
// Byte range header parser: single-range HTTP Range header evaluator.
// Depends on brhp_pkg and byte_range_header_parser_top_macros.svh.
//
// Usage:
//   The item channel (item_valid/item_ready/item) carries one header character
//   per transaction with the object size; is_final marks the last one. An item
//   with char_present low carries no character. Every final item yields exactly
//   one transaction on the result channel (result_valid/result_ready/result).
//   Pipeline: input register, parse state update and snapshot, range compare,
//   result register. A final item's result passes the snapshot, range and
//   result registers in that order before it shows on result_valid.
//   Throughput is one item per cycle while no final item waits on a full
//   stage; the parse state register applies a 10x multiply-accumulate with
//   saturation per item, so items follow back to back. Each stage holds its
//   item while the next is full, so a stalled receiver fills at most the three
//   result-bearing stages; non-final characters pass until a final item waits.
//   Reset clears all valid flags and returns the parser to the prefix phase.
//   After each final item the parse state returns to that reset state.
`include "byte_range_header_parser_top_macros.svh"

module byte_range_header_parser_top
    import brhp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int W  = OFFSET_BITS;
    localparam int MW = W + 4;
    localparam int SW = (W > FIELD_BITS) ? W : FIELD_BITS;
    localparam int XW = (W + 1 > FIELD_BITS) ? W + 1 : FIELD_BITS;
    localparam logic [W-1:0] OFS_MAX = '1;

    // input register
    logic     a_valid_reg;
    in_item_t a_item_reg;
    logic     a_consume;

    // parse state
    logic [2:0]   pos_reg, pos_next, pos_step;
    phase_t       phase_reg, phase_next, phase_step;
    logic         failed_reg, failed_next, failed_step;
    logic [W-1:0] first_reg, first_next, first_step;
    logic         first_has_reg, first_has_next, first_has_step;
    logic [W-1:0] second_reg, second_next, second_step;
    logic         second_has_reg, second_has_next, second_has_step;

    // snapshot stage
    logic         j_valid_reg;
    logic         j_form_ok_reg;
    logic [W-1:0] j_first_reg, j_second_reg, j_size_reg;
    logic         j_first_has_reg, j_second_has_reg;
    logic         j_free;

    // range stage
    logic         c_valid_reg;
    logic         c_ok_reg, c_ok_next;
    logic [W-1:0] c_start_reg, c_start_next, c_end_reg, c_end_next;
    logic         c_free;

    // result register
    logic      result_valid_reg;
    out_item_t result_reg, result_next;
    logic      o_free;

    logic [7:0]    ch;
    logic [7:0]    digit_diff;
    logic [W-1:0]  acc_sel;
    logic [MW-1:0] acc_prod;
    logic [W-1:0]  acc_new;
    logic [SW-1:0] size_ext;
    logic [W-1:0]  size_sat;

    // ready chain, output side first
    assign o_free     = !result_valid_reg || result_ready;
    assign c_free     = !c_valid_reg || o_free;
    assign j_free     = !j_valid_reg || c_free;
    assign a_consume  = a_valid_reg && (!a_item_reg.is_final || j_free);
    assign item_ready = !a_valid_reg || a_consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            a_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            a_item_reg <= item;
        end
    end

    // one character step of the parser
    assign ch         = a_item_reg.header_char;
    assign digit_diff = ch - CH_ZERO;
    assign acc_sel    = (phase_reg == PH_FIRST) ? first_reg : second_reg;
    assign acc_prod   = (MW'(acc_sel) << 3) + (MW'(acc_sel) << 1) + MW'(digit_diff[3:0]);
    assign acc_new    = (acc_prod > MW'(OFS_MAX)) ? OFS_MAX : acc_prod[W-1:0];

    always_comb
    begin
        pos_step        = pos_reg;
        phase_step      = phase_reg;
        failed_step     = failed_reg;
        first_step      = first_reg;
        first_has_step  = first_has_reg;
        second_step     = second_reg;
        second_has_step = second_has_reg;
        if (a_item_reg.char_present && !failed_reg)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (pos_reg < 3'(PREFIX_LEN) && ch == lead_char(pos_reg))
                    begin
                        pos_step = pos_reg + 3'd1;
                        if (pos_reg == 3'(PREFIX_LEN - 1))
                        begin
                            phase_step = PH_FIRST;
                        end
                    end
                    else
                    begin
                        failed_step = 1'b1;
                    end
                end
                PH_FIRST, PH_SECOND:
                begin
                    if (ch inside {[CH_ZERO:CH_NINE]})
                    begin
                        if (phase_reg == PH_FIRST)
                        begin
                            first_step     = acc_new;
                            first_has_step = 1'b1;
                        end
                        else
                        begin
                            second_step     = acc_new;
                            second_has_step = 1'b1;
                        end
                    end
                    else if (ch == CH_DASH && phase_reg == PH_FIRST)
                    begin
                        phase_step = PH_SECOND;
                    end
                    else
                    begin
                        failed_step = 1'b1;
                    end
                end
                default:
                begin
                    failed_step = 1'b1;
                end
            endcase
        end
    end

    // final item returns the parser to its reset state
    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        failed_next     = failed_reg;
        first_next      = first_reg;
        first_has_next  = first_has_reg;
        second_next     = second_reg;
        second_has_next = second_has_reg;
        if (a_consume)
        begin
            if (a_item_reg.is_final)
            begin
                pos_next        = 3'd0;
                phase_next      = PH_PREFIX;
                failed_next     = 1'b0;
                first_next      = '0;
                first_has_next  = 1'b0;
                second_next     = '0;
                second_has_next = 1'b0;
            end
            else
            begin
                pos_next        = pos_step;
                phase_next      = phase_step;
                failed_next     = failed_step;
                first_next      = first_step;
                first_has_next  = first_has_step;
                second_next     = second_step;
                second_has_next = second_has_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 3'd0;
            phase_reg      <= PH_PREFIX;
            failed_reg     <= 1'b0;
            first_reg      <= '0;
            first_has_reg  <= 1'b0;
            second_reg     <= '0;
            second_has_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            failed_reg     <= failed_next;
            first_reg      <= first_next;
            first_has_reg  <= first_has_next;
            second_reg     <= second_next;
            second_has_reg <= second_has_next;
        end
    end

    // object size saturated to the offset width
    assign size_ext = SW'(a_item_reg.object_size);
    assign size_sat = (size_ext > SW'(OFS_MAX)) ? OFS_MAX : size_ext[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
        end
        else if (j_free)
        begin
            j_valid_reg <= a_consume && a_item_reg.is_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (j_free && a_consume && a_item_reg.is_final)
        begin
            j_form_ok_reg    <= !failed_step && phase_step == PH_SECOND;
            j_first_reg      <= first_step;
            j_first_has_reg  <= first_has_step;
            j_second_reg     <= second_step;
            j_second_has_reg <= second_has_step;
            j_size_reg       <= size_sat;
        end
    end

    // range selection and clamping
    always_comb
    begin
        logic [W-1:0] size_m1;
        logic [W-1:0] end_e;
        logic         ok_form;
        size_m1 = j_size_reg - W'(1);
        end_e   = j_second_has_reg ? j_second_reg : size_m1;
        if (end_e >= j_size_reg)
        begin
            end_e = size_m1;
        end
        ok_form = j_form_ok_reg && (j_size_reg != '0);
        if (j_first_has_reg)
        begin
            c_start_next = j_first_reg;
            c_end_next   = end_e;
            c_ok_next    = ok_form && (j_first_reg <= end_e);
        end
        else
        begin
            c_start_next = (j_second_reg >= j_size_reg) ? '0 : j_size_reg - j_second_reg;
            c_end_next   = size_m1;
            c_ok_next    = ok_form && j_second_has_reg && (j_second_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free && j_valid_reg)
        begin
            c_ok_reg    <= c_ok_next;
            c_start_reg <= c_start_next;
            c_end_reg   <= c_end_next;
        end
    end

    // length needs one extra bit when the offset width reaches the field width
    always_comb
    begin
        logic [XW-1:0] ext_first;
        logic [XW-1:0] ext_last;
        logic [XW-1:0] ext_len;
        ext_first = XW'(c_start_reg);
        ext_last  = XW'(c_end_reg);
        ext_len   = ext_last - ext_first + XW'(1);
        if (c_ok_reg)
        begin
            result_next.satisfiable  = 1'b1;
            result_next.range_first  = ext_first[FIELD_BITS-1:0];
            result_next.range_last   = ext_last[FIELD_BITS-1:0];
            result_next.range_length = ext_len[FIELD_BITS-1:0];
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (o_free)
        begin
            result_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_free && c_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BRHP_ASSERT_NOW(a_prefix_done, phase_reg != PH_PREFIX, pos_reg == 3'(PREFIX_LEN), "prefix position lost after prefix phase")
    `BRHP_ASSERT_NOW(a_range_order, c_valid_reg && c_ok_reg, c_start_reg <= c_end_reg, "range start beyond range end")
    `BRHP_ASSERT_NOW(a_reject_zero, result_valid && !result.satisfiable, result.range_first == '0 && result.range_last == '0 && result.range_length == '0, "rejected range carries nonzero fields")
    `BRHP_ASSERT_NEXT(a_final_clears, a_consume && a_item_reg.is_final, phase_reg == PH_PREFIX && pos_reg == 3'd0 && !failed_reg, "parser not cleared after final item")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for byte_range_header_parser_top: drives Range header characters,
// predicts each final transaction's range and checks results in order.
// Depends on brhp_pkg and the byte_range_header_parser_top RTL.

module testbench;
    import brhp_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int TAIL_ITEMS = 150;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_EVERY = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [63:0] OFS_MAX = (64'd1 << OFFSET_BITS_DEFAULT) - 64'd1;
    localparam logic [FIELD_BITS-1:0] FULL_SIZE = '1;

    typedef struct packed {
        logic     wait_drain;
        in_item_t data;
    } pending_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    wire in_fire  = item_valid && item_ready;
    wire out_fire = result_valid && result_ready;

    pending_t   header_items[$];
    out_item_t  expected_ranges[$];
    logic [7:0] hdr_buf[$];
    string      range_unit = "bytes=";

    int  stim_items = 0;
    int  accepted_items = 0;
    int  mismatches = 0;
    int  stall_cycles = 0;
    int  send_gap_left = 0;
    int  recv_hold_left = 0;
    bit  long_hold_done = 1'b0;
    logic in_fired = 1'b0;

    // parse state mirror
    logic [2:0]  unit_pos;
    phase_t      parse_phase;
    logic        parse_failed;
    logic [63:0] first_num;
    logic [63:0] second_num;
    logic        first_seen;
    logic        second_seen;

    byte_range_header_parser_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // ---------------- range predictor ----------------

    task automatic clear_parse_state();
        unit_pos     = 3'd0;
        parse_phase  = PH_PREFIX;
        parse_failed = 1'b0;
        first_num    = 64'd0;
        second_num   = 64'd0;
        first_seen   = 1'b0;
        second_seen  = 1'b0;
    endtask

    function automatic logic [63:0] push_decimal(logic [63:0] acc, logic [63:0] d);
        if (acc > (OFS_MAX - d) / 64'd10)
            return OFS_MAX;
        return acc * 64'd10 + d;
    endfunction

    task automatic feed_char(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (!parse_failed)
        begin
            if (parse_phase == PH_PREFIX)
            begin
                if (unit_pos < PREFIX_LEN && c == range_unit.getc(unit_pos))
                begin
                    unit_pos = unit_pos + 3'd1;
                    if (unit_pos == PREFIX_LEN)
                        parse_phase = PH_FIRST;
                end
                else
                    parse_failed = 1'b1;
            end
            else if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (parse_phase == PH_FIRST)
                begin
                    first_num  = push_decimal(first_num, d);
                    first_seen = 1'b1;
                end
                else
                begin
                    second_num  = push_decimal(second_num, d);
                    second_seen = 1'b1;
                end
            end
            else if (c == CH_DASH && parse_phase == PH_FIRST)
                parse_phase = PH_SECOND;
            else
                parse_failed = 1'b1;
        end
    endtask

    task automatic parse_header_item(in_item_t it);
        out_item_t   r;
        logic [63:0] size;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        logic        ok;
        if (it.char_present)
            feed_char(it.header_char);
        if (it.is_final)
        begin
            size = 64'(it.object_size);
            if (size > OFS_MAX)
                size = OFS_MAX;
            lo = 64'd0;
            hi = 64'd0;
            ok = 1'b0;
            if (!parse_failed && parse_phase == PH_SECOND && size != 64'd0)
            begin
                if (!first_seen)
                begin
                    // suffix form: last N bytes
                    if (second_seen && second_num != 64'd0)
                    begin
                        lo = (second_num >= size) ? 64'd0 : size - second_num;
                        hi = size - 64'd1;
                        ok = 1'b1;
                    end
                end
                else
                begin
                    lo = first_num;
                    hi = second_seen ? second_num : size - 64'd1;
                    if (hi >= size)
                        hi = size - 64'd1;
                    ok = (lo <= hi) && (lo < size);
                end
            end
            r = '0;
            if (ok)
            begin
                span = hi - lo + 64'd1;
                r.satisfiable  = 1'b1;
                r.range_first  = lo[FIELD_BITS-1:0];
                r.range_last   = hi[FIELD_BITS-1:0];
                r.range_length = span[FIELD_BITS-1:0];
            end
            expected_ranges.insert(expected_ranges.size(), r);
            clear_parse_state();
        end
    endtask

    // ---------------- stimulus building ----------------

    function automatic logic [FIELD_BITS-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[FIELD_BITS-1:0];
    endfunction

    task automatic put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            hdr_buf.insert(hdr_buf.size(), s.getc(i));
    endtask

    task automatic put_digits(int n);
        repeat (n)
            hdr_buf.insert(hdr_buf.size(), CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_number();
        logic [FIELD_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: put_digits($urandom_range(14, 22));
            1:
            begin
                put_text("0");
                put_text($sformatf("%0d", $urandom_range(0, 99)));
            end
            2, 3, 4, 5: put_text($sformatf("%0d", $urandom_range(0, 6000)));
            default:
            begin
                v = rand48() >> $urandom_range(0, 47);
                put_text($sformatf("%0d", v));
            end
        endcase
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FULL_SIZE;
            2, 3:    return rand48();
            default: return FIELD_BITS'($urandom_range(1, 6000));
        endcase
    endfunction

    task automatic push_item(in_item_t it, bit drain, bit counted);
        header_items.insert(header_items.size(), {drain, it});
        if (counted)
            stim_items++;
    endtask

    // turn hdr_buf into item transactions; object_size only matters on the final one
    task automatic queue_header(logic [FIELD_BITS-1:0] size, bit blank_final, bit sprinkle,
                                bit drain);
        in_item_t it;
        int       i;
        bit       lead;
        lead = drain;
        for (i = 0; i < hdr_buf.size(); i++)
        begin
            if (sprinkle && $urandom_range(0, 19) == 0)
            begin
                it.header_char  = 8'($urandom_range(0, 255));
                it.char_present = 1'b0;
                it.is_final     = 1'b0;
                it.object_size  = rand48();
                push_item(it, lead, 1'b0);
                lead = 1'b0;
            end
            it.header_char  = hdr_buf[i];
            it.char_present = 1'b1;
            it.is_final     = (i == hdr_buf.size() - 1) && !blank_final;
            it.object_size  = it.is_final ? size : rand48();
            push_item(it, lead, 1'b1);
            lead = 1'b0;
        end
        if (blank_final || hdr_buf.size() == 0)
        begin
            it.header_char  = 8'($urandom_range(0, 255));
            it.char_present = 1'b0;
            it.is_final     = 1'b1;
            it.object_size  = size;
            push_item(it, lead, 1'b1);
        end
        hdr_buf.delete();
    endtask

    task automatic queue_text(string s, logic [FIELD_BITS-1:0] size);
        hdr_buf.delete();
        put_text(s);
        queue_header(size, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic queue_random_header(bit drain);
        logic [FIELD_BITS-1:0] size;
        int n;
        int pos;
        int k;
        size = pick_size();
        hdr_buf.delete();
        if ($urandom_range(0, 9) < 7)
        begin
            put_text(range_unit);
            case ($urandom_range(0, 2))
                0:
                begin
                    put_text("-");
                    if ($urandom_range(0, 11) != 0)
                        put_number();
                end
                1:
                begin
                    put_number();
                    put_text("-");
                end
                default:
                begin
                    put_number();
                    put_text("-");
                    put_number();
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    n = $urandom_range(0, 10);
                    repeat (n)
                        hdr_buf.insert(hdr_buf.size(), 8'($urandom_range(0, 255)));
                end
                1:
                begin
                    put_text(range_unit);
                    pos = $urandom_range(0, PREFIX_LEN - 1);
                    hdr_buf[pos] = 8'($urandom_range(0, 255));
                    put_text("1-2");
                end
                2:
                begin
                    put_text(range_unit);
                    put_number();
                    put_text("-");
                    put_number();
                    put_text(",");
                    put_number();
                    put_text("-");
                end
                3:
                begin
                    put_text(range_unit);
                    put_number();
                    put_text("-");
                    put_number();
                    pos = $urandom_range(PREFIX_LEN, hdr_buf.size());
                    if ($urandom_range(0, 1) == 0)
                        hdr_buf.insert(pos, CH_DASH);
                    else
                        hdr_buf.insert(pos, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    n = $urandom_range(0, PREFIX_LEN - 1);
                    for (k = 0; k < n; k++)
                        hdr_buf.insert(hdr_buf.size(), range_unit.getc(k));
                end
            endcase
        end
        queue_header(size, $urandom_range(0, 9) == 0, 1'b1, drain);
    endtask

    // ---------------- driver / receiver ----------------

    always @(negedge clk)
    begin : drive_items
        pending_t nxt;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || in_fired)
        begin
            if (send_gap_left > 0)
            begin
                send_gap_left = send_gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (header_items.size() == 0 ||
                     (header_items[0].wait_drain && expected_ranges.size() != 0))
                item_valid <= 1'b0;
            else if (header_items.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0)
            begin
                send_gap_left = $urandom_range(1, 14) - 1;
                item_valid <= 1'b0;
            end
            else
            begin
                nxt = header_items.pop_front();
                item <= nxt.data;
                item_valid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            result_ready <= 1'b0;
        else if (recv_hold_left > 0)
        begin
            recv_hold_left = recv_hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!long_hold_done && accepted_items >= LONG_HOLD_AT)
        begin
            // long back-pressure so the pipeline fills and stalls the input
            long_hold_done = 1'b1;
            recv_hold_left = LONG_HOLD_CYCLES - 1;
            result_ready <= 1'b0;
        end
        else if (header_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
        begin
            recv_hold_left = $urandom_range(1, 14) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("range check: %s: exp sat=%0b first=%0d last=%0d len=%0d",
                     what, want.satisfiable, want.range_first, want.range_last,
                     want.range_length);
            $display("range check: %s: got sat=%0b first=%0d last=%0d len=%0d",
                     what, got.satisfiable, got.range_first, got.range_last,
                     got.range_length);
        end
    endtask

    always @(posedge clk)
    begin : watch_ports
        out_item_t want;
        if (!rst_n)
            in_fired <= 1'b0;
        else
        begin
            in_fired <= in_fire;
            if (in_fire)
            begin
                accepted_items++;
                parse_header_item(item);
            end
            if (out_fire)
            begin
                if (expected_ranges.size() == 0)
                    report_mismatch("unexpected result", '0, result);
                else
                begin
                    want = expected_ranges.pop_front();
                    if (result.satisfiable !== want.satisfiable ||
                        result.range_first !== want.range_first ||
                        result.range_last !== want.range_last ||
                        result.range_length !== want.range_length)
                        report_mismatch("wrong field", want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || in_fire || out_fire)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_CYCLES)
        begin
            $display("byte_range_header_parser_top: mismatch");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        in_item_t blank;
        int next_drain;
        clear_parse_state();

        // directed headers
        queue_text("bytes=0-499", 48'd1000);
        queue_text("bytes=500-", 48'd1000);
        queue_text("bytes=-200", 48'd1000);
        queue_text("bytes=-0", 48'd1000);
        queue_text("bytes=-", 48'd1000);
        queue_text("bytes=0-1,2-3", 48'd1000);
        queue_text("bytes=1-2-3", 48'd1000);
        queue_text("bytes=5", 48'd1000);
        queue_text("byt", 48'd1000);
        queue_text("", 48'd1000);
        queue_text("bytes=0-99999999999999999999999", FULL_SIZE);
        queue_text("bytes=99999999999999999999-", FULL_SIZE);
        queue_text("bytes=-281474976710655", FULL_SIZE);
        queue_text("bytes=0-", 48'd0);
        queue_text("bytes=-5000", 48'd1000);
        queue_text("bytes=10-5", 48'd1000);
        queue_text("bytes=2000-3000", 48'd1000);
        queue_text("bytes=0-0", 48'd1);
        queue_text("Bytes=0-1", 48'd1000);
        queue_text("bytes=x123-4", 48'd1000);
        hdr_buf.delete();
        put_text("bytes=1");
        hdr_buf.insert(hdr_buf.size(), 8'hFF);
        queue_header(48'd1000, 1'b0, 1'b0, 1'b0);
        hdr_buf.delete();
        put_text("bytes=");
        hdr_buf.insert(hdr_buf.size(), 8'h00);
        queue_header(48'd1000, 1'b0, 1'b0, 1'b0);
        // ignored character-less transaction, then a header judged on a blank final
        blank.header_char  = 8'hA5;
        blank.char_present = 1'b0;
        blank.is_final     = 1'b0;
        blank.object_size  = FULL_SIZE;
        push_item(blank, 1'b0, 1'b0);
        hdr_buf.delete();
        put_text("bytes=1-2");
        queue_header(48'd1000, 1'b1, 1'b0, 1'b0);

        // random headers up to the item budget, with a full drain before some of them
        next_drain = DRAIN_EVERY;
        while (stim_items < RANDOM_ITEMS)
        begin
            if (stim_items >= next_drain)
            begin
                next_drain = next_drain + DRAIN_EVERY;
                queue_random_header(1'b1);
            end
            else
                queue_random_header(1'b0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        #1 rst_n = 1'b1;

        while (header_items.size() != 0 || item_valid || expected_ranges.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_ranges.size() == 0)
            $display("byte_range_header_parser_top: match");
        else
            $display("byte_range_header_parser_top: mismatch");
        $finish;
    end

endmodule
